// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the flash trigger controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg
// Types, codes and constants shared by the flash trigger controller modules.
// ----------------------------------------------------------------------------
package ftc_pkg;

   // default width of the outbound and pending-ack ids
   localparam int ID_BITS_DEFAULT = 8;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // reset values of the configuration registers
   localparam logic [7:0]  REGULAR_WARM_RST        = 8'd127;
   localparam logic [7:0]  REGULAR_COOL_RST        = 8'd127;
   localparam logic [15:0] REGULAR_TIMEOUT_MS_RST  = 16'd5000;
   localparam logic [7:0]  PREFLASH_WARM_RST       = 8'd63;
   localparam logic [7:0]  PREFLASH_COOL_RST       = 8'd63;
   localparam logic [15:0] PREFLASH_TIMEOUT_MS_RST = 16'd10000;

   // HID media key codes
   localparam logic [7:0] KEY_VOL_UP  = 8'h20;
   localparam logic [7:0] KEY_RELEASE = 8'h00;

   typedef enum logic [2:0] {
      REG_REGULAR_WARM        = 3'd0,
      REG_REGULAR_COOL        = 3'd1,
      REG_REGULAR_TIMEOUT_MS  = 3'd2,
      REG_PREFLASH_WARM       = 3'd3,
      REG_PREFLASH_COOL       = 3'd4,
      REG_PREFLASH_TIMEOUT_MS = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_APP_CONNECT    = 3'd0,
      MODE_APP_DISCONNECT = 3'd1,
      MODE_HID_CONNECT    = 3'd2,
      MODE_HID_DISCONNECT = 3'd3,
      MODE_PRESS          = 3'd4,
      MODE_RELEASE        = 3'd5,
      MODE_COMMAND        = 3'd6,
      MODE_TICK           = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      CMD_PING  = 3'd0,
      CMD_FLASH = 3'd1,
      CMD_OFF   = 3'd2,
      CMD_ACK   = 3'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_TRIGGER = 2'd1,
      KIND_ACK     = 2'd2
   } send_kind_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  cmd_type;
      logic [7:0]  cmd_id;
      logic [7:0]  flash_warm;
      logic [7:0]  flash_cool;
      logic [15:0] flash_timeout_ms;
   } req_item_type;

   typedef struct packed {
      logic [7:0] light_warm;
      logic [7:0] light_cool;
      logic       status_led;
      logic [1:0] send_kind;
      logic [7:0] send_id;
      logic       trigger_pressed;
      logic       hid_key_valid;
      logic [7:0] hid_key;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  regular_warm;
      logic [7:0]  regular_cool;
      logic [15:0] regular_timeout_ms;
      logic [7:0]  preflash_warm;
      logic [7:0]  preflash_cool;
      logic [15:0] preflash_timeout_ms;
   } cfg_type;

   // engine to result buffer
   typedef struct packed {
      logic push;
      logic two;
   } push_type;

endpackage

// File: hw/rtl/ftc_csr.sv
// ----------------------------------------------------------------------------
// ftc_csr
// APB-style configuration registers for the flash levels and durations.
// ----------------------------------------------------------------------------
module ftc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ftc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ftc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ftc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output ftc_pkg::cfg_type                cfg
);
   import ftc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_REGULAR_WARM:        cfg_in.regular_warm        = csr_pwdata[7:0];
            REG_REGULAR_COOL:        cfg_in.regular_cool        = csr_pwdata[7:0];
            REG_REGULAR_TIMEOUT_MS:  cfg_in.regular_timeout_ms  = csr_pwdata[15:0];
            REG_PREFLASH_WARM:       cfg_in.preflash_warm       = csr_pwdata[7:0];
            REG_PREFLASH_COOL:       cfg_in.preflash_cool       = csr_pwdata[7:0];
            REG_PREFLASH_TIMEOUT_MS: cfg_in.preflash_timeout_ms = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.regular_warm        <= REGULAR_WARM_RST;
         cfg_ff.regular_cool        <= REGULAR_COOL_RST;
         cfg_ff.regular_timeout_ms  <= REGULAR_TIMEOUT_MS_RST;
         cfg_ff.preflash_warm       <= PREFLASH_WARM_RST;
         cfg_ff.preflash_cool       <= PREFLASH_COOL_RST;
         cfg_ff.preflash_timeout_ms <= PREFLASH_TIMEOUT_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_REGULAR_WARM:        csr_prdata = CSR_DATA_W'(cfg_ff.regular_warm);
         REG_REGULAR_COOL:        csr_prdata = CSR_DATA_W'(cfg_ff.regular_cool);
         REG_REGULAR_TIMEOUT_MS:  csr_prdata = CSR_DATA_W'(cfg_ff.regular_timeout_ms);
         REG_PREFLASH_WARM:       csr_prdata = CSR_DATA_W'(cfg_ff.preflash_warm);
         REG_PREFLASH_COOL:       csr_prdata = CSR_DATA_W'(cfg_ff.preflash_cool);
         REG_PREFLASH_TIMEOUT_MS: csr_prdata = CSR_DATA_W'(cfg_ff.preflash_timeout_ms);
         default:                 csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/ftc_engine.sv
// ----------------------------------------------------------------------------
// ftc_engine
// Controller state and event decode: updates links, lights, ids and the
// countdown for one item and builds its one or two result items.
// ----------------------------------------------------------------------------
module ftc_engine #(
   parameter int ID_BITS = ftc_pkg::ID_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ftc_pkg::req_item_type item,
   input  ftc_pkg::cfg_type      cfg,
   output ftc_pkg::push_type     push,
   output ftc_pkg::rsp_item_type res0,
   output ftc_pkg::rsp_item_type res1
);
   import ftc_pkg::*;

   // common width for id compares and the 8-bit send id
   localparam int IdW = (ID_BITS > 8) ? ID_BITS : 8;

   logic               app_ff, app_in, hid_ff, hid_in, lit_ff, lit_in;
   logic [7:0]         warm_ff, warm_in, cool_ff, cool_in;
   logic [ID_BITS-1:0] outbound_ff, outbound_in, pending_ff, pending_in;
   logic [15:0]        left_ff, left_in;
   logic               active_ff, active_in;

   logic               do_off, do_on, two, pressed;
   logic [7:0]         on_w, on_c;
   logic [15:0]        on_d;
   send_kind_type      kind;
   logic [7:0]         sid;
   logic [ID_BITS-1:0] out_next;
   logic [IdW-1:0]     out_ext;
   mode_type           mode;

   assign mode     = mode_type'(item.mode);
   // next outbound id wraps at the id width
   assign out_next = outbound_ff + 1'b1;
   assign out_ext  = IdW'(out_next);

   // event decode
   always_comb begin
      app_in      = app_ff;
      hid_in      = hid_ff;
      outbound_in = outbound_ff;
      pending_in  = pending_ff;
      do_off      = 1'b0;
      do_on       = 1'b0;
      on_w        = cfg.regular_warm;
      on_c        = cfg.regular_cool;
      on_d        = cfg.regular_timeout_ms;
      two         = 1'b0;
      kind        = KIND_NONE;
      sid         = '0;
      pressed     = 1'b0;
      unique case (mode)
         MODE_APP_CONNECT: app_in = 1'b1;
         MODE_APP_DISCONNECT: begin
            app_in = 1'b0;
            do_off = !hid_ff;
         end
         MODE_HID_CONNECT: hid_in = 1'b1;
         MODE_HID_DISCONNECT: begin
            hid_in = 1'b0;
            do_off = !app_ff;
         end
         MODE_PRESS: begin
            do_on = 1'b1;
            on_w  = cfg.preflash_warm;
            on_c  = cfg.preflash_cool;
            on_d  = cfg.preflash_timeout_ms;
            if (app_ff) begin
               outbound_in = out_next;
               kind        = KIND_TRIGGER;
               sid         = out_ext[7:0];
               pressed     = 1'b1;
            end
         end
         MODE_RELEASE: begin
            if (app_ff) begin
               do_on       = 1'b1;
               outbound_in = out_next;
               pending_in  = out_next;
               kind        = KIND_TRIGGER;
               sid         = out_ext[7:0];
            end else if (hid_ff) begin
               do_on = 1'b1;
               two   = 1'b1;
            end else begin
               do_off = 1'b1;
            end
         end
         MODE_COMMAND: begin
            case (item.cmd_type)
               CMD_PING: begin
                  kind = KIND_ACK;
                  sid  = item.cmd_id;
               end
               CMD_FLASH: begin
                  do_on = 1'b1;
                  on_w  = item.flash_warm;
                  on_c  = item.flash_cool;
                  on_d  = item.flash_timeout_ms;
                  kind  = KIND_ACK;
                  sid   = item.cmd_id;
               end
               CMD_OFF: begin
                  do_off = 1'b1;
                  kind   = KIND_ACK;
                  sid    = item.cmd_id;
               end
               CMD_ACK: begin
                  if (IdW'(pending_ff) == IdW'(item.cmd_id)) begin
                     do_off     = 1'b1;
                     pending_in = '0;
                  end
               end
               default: ;
            endcase
         end
         MODE_TICK: do_off = active_ff && (left_ff <= 16'd1);
         default: ;
      endcase
   end

   // light and countdown update
   always_comb begin
      lit_in    = lit_ff;
      warm_in   = warm_ff;
      cool_in   = cool_ff;
      left_in   = left_ff;
      active_in = active_ff;
      if (do_off) begin
         lit_in    = 1'b0;
         warm_in   = '0;
         cool_in   = '0;
         left_in   = '0;
         active_in = 1'b0;
      end else if (do_on) begin
         warm_in = on_w;
         cool_in = on_c;
         lit_in  = (on_w != 8'd0) && (on_c != 8'd0);
         if (lit_in) begin
            left_in   = on_d;
            active_in = 1'b1;
         end
      end else if (mode == MODE_TICK && active_ff) begin
         left_in = left_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         app_ff      <= 1'b0;
         hid_ff      <= 1'b0;
         lit_ff      <= 1'b0;
         warm_ff     <= '0;
         cool_ff     <= '0;
         outbound_ff <= '0;
         pending_ff  <= '0;
         left_ff     <= '0;
         active_ff   <= 1'b0;
      end else if (fire) begin
         app_ff      <= app_in;
         hid_ff      <= hid_in;
         lit_ff      <= lit_in;
         warm_ff     <= warm_in;
         cool_ff     <= cool_in;
         outbound_ff <= outbound_in;
         pending_ff  <= pending_in;
         left_ff     <= left_in;
         active_ff   <= active_in;
      end
   end

   // result items, built from the state after the event
   always_comb begin
      res0.light_warm      = warm_in;
      res0.light_cool      = cool_in;
      res0.status_led      = (app_in || hid_in) && !lit_in;
      res0.send_kind       = kind;
      res0.send_id         = sid;
      res0.trigger_pressed = pressed;
      res0.hid_key_valid   = two;
      res0.hid_key         = two ? KEY_VOL_UP : KEY_RELEASE;
      res0.last            = !two;
      res1                 = res0;
      res1.hid_key         = KEY_RELEASE;
      res1.last            = 1'b1;
   end

   assign push.push = fire;
   assign push.two  = two;

endmodule

// File: hw/rtl/ftc_rsp_buf.sv
// ----------------------------------------------------------------------------
// ftc_rsp_buf
// Two-slot result register: the output slot plus one slot for the second
// key item of a HID release.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ftc_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  ftc_pkg::push_type     push,
   input  ftc_pkg::rsp_item_type res0,
   input  ftc_pkg::rsp_item_type res1,
   output logic                  can_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ftc_pkg::rsp_item_type rsp_data
);
   import ftc_pkg::*;

   logic         slot0_valid_ff, slot0_valid_in, slot1_valid_ff, slot1_valid_in;
   rsp_item_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic         pop;

   assign pop      = slot0_valid_ff && !rsp_stall;
   // an event may need both slots, so only take one when slot 1 is free
   assign can_take = !slot1_valid_ff && (!slot0_valid_ff || pop);

   always_comb begin
      slot0_valid_in = slot0_valid_ff;
      slot1_valid_in = slot1_valid_ff;
      slot0_in       = slot0_ff;
      slot1_in       = slot1_ff;
      if (push.push) begin
         slot0_valid_in = 1'b1;
         slot0_in       = res0;
         slot1_valid_in = push.two;
         slot1_in       = res1;
      end else if (pop) begin
         slot0_valid_in = slot1_valid_ff;
         slot0_in       = slot1_ff;
         slot1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_valid_ff <= 1'b0;
         slot1_valid_ff <= 1'b0;
      end else begin
         slot0_valid_ff <= slot0_valid_in;
         slot1_valid_ff <= slot1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid = slot0_valid_ff;
   assign rsp_data  = slot0_ff;

   `ASSERT_IMPLIES(a_slot1_behind_slot0, clock, reset, slot1_valid_ff, slot0_valid_ff, "slot 1 full while output slot empty")
   `ASSERT_IMPLIES(a_first_not_last, clock, reset, slot1_valid_ff, !slot0_ff.last, "first of two items marked last")
   `ASSERT_NEXT(a_pair_held, clock, reset, push.push && push.two, slot1_valid_ff && slot0_valid_ff, "second key item lost")
   `ASSERT_IMPLIES(a_push_room, clock, reset, push.push, can_take, "item pushed without room")

endmodule

// File: hw/rtl/flash_trigger_controller_core.sv
// ----------------------------------------------------------------------------
// flash_trigger_controller_core
// Event-driven camera-flash light controller: link flags, light levels,
// trigger/ack commands, HID keys and the flash countdown.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event item (req_data) under valid/stall; rsp_* returns
//   its result items. Every event gives one result item, except a release
//   while only the HID link is up, which gives two (key 0x20, then key 0x00,
//   the second marked last).
//   csr_* is an APB-style port for the flash levels and durations at byte
//   addresses 0, 4, ... 20; pready is tied high. Write it while idle.
//   An accepted item is held in the input register; its first result is
//   registered into the result slots when the item fires, which waits for
//   room there. Throughput: one item per cycle while rsp is not stalled; a
//   two-result event holds the input register while the result register drains.
//   The rate is set by the two-slot result register feeding one output.
//   Reset: links down, lights off, ids and countdown cleared, registers at
//   their defaults. A stall on rsp holds the result items in place; the
//   input side then stalls once the input register and the output slot fill.
// ----------------------------------------------------------------------------
module flash_trigger_controller_core #(
   parameter int ID_BITS = ftc_pkg::ID_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ftc_pkg::req_item_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ftc_pkg::rsp_item_type           rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ftc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ftc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ftc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import ftc_pkg::*;

   logic         item_valid_ff, item_valid_in;
   req_item_type item_ff;
   logic         accept, fire, can_take;
   cfg_type      cfg;
   push_type     push;
   rsp_item_type res0, res1;

   // input register
   assign fire      = item_valid_ff && can_take;
   assign req_stall = item_valid_ff && !can_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   ftc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ftc_engine #(
      .ID_BITS (ID_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item_ff),
      .cfg   (cfg),
      .push  (push),
      .res0  (res0),
      .res1  (res1)
   );

   ftc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .res0      (res0),
      .res1      (res1),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/flash_trigger_controller_core_tb.sv
// ----------------------------------------------------------------------------
// flash_trigger_controller_core_tb
// Self-checking bench for the flash trigger controller. Event items go in on
// req_*, and a local model of the links, lights, ids and countdown predicts
// every result item. Each result on rsp_* is compared field by field. The
// CSR port is read back in a register test and rewritten between traffic
// phases. Both sides idle in random bursts, except in some phases and in the last one.
// ----------------------------------------------------------------------------
module flash_trigger_controller_core_tb;
   import ftc_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int DRAIN_CYCLES  = 10;
   localparam int RUN_LIMIT     = 6000000;
   localparam int PHASE_EVENTS  = 260;

   // DUT ports
   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   req_item_type            req_data    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   rsp_item_type            rsp_data;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // controller model state
   cfg_type      cfg_shadow;
   logic         app_up, hid_up, lit, countdown_on;
   logic [7:0]   warm_now, cool_now, trigger_id, awaited_ack;
   logic [15:0]  ticks_left;

   rsp_item_type due_results[$];
   int unsigned  mismatches  = 0;
   int unsigned  events_sent = 0;
   bit           req_idle_on = 1'b1;
   bit           rsp_idle_on = 1'b1;
   int unsigned  stall_left  = 0;

   flash_trigger_controller_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic rsp_item_type result_now(send_kind_type kind, logic [7:0] id,
         logic pressed, logic key_valid, logic [7:0] key, logic is_last);
      rsp_item_type r;
      r.light_warm      = warm_now;
      r.light_cool      = cool_now;
      r.status_led      = (app_up || hid_up) && !lit;
      r.send_kind       = kind;
      r.send_id         = id;
      r.trigger_pressed = pressed;
      r.hid_key_valid   = key_valid;
      r.hid_key         = key;
      r.last            = is_last;
      return r;
   endfunction

   task automatic lights_off();
      countdown_on = 1'b0;
      ticks_left   = '0;
      warm_now     = '0;
      cool_now     = '0;
      lit          = 1'b0;
   endtask

   // only a flash with both channels on arms the countdown
   task automatic lights_on(logic [7:0] w, logic [7:0] c, logic [15:0] dur);
      warm_now = w;
      cool_now = c;
      lit      = (w != 0) && (c != 0);
      if (lit) begin
         ticks_left   = dur;
         countdown_on = 1'b1;
      end
   endtask

   // apply one accepted event and queue the result items it causes
   task automatic advance_controller(req_item_type ev);
      send_kind_type kind    = KIND_NONE;
      logic [7:0]    id      = '0;
      logic          pressed = 1'b0;
      case (mode_type'(ev.mode))
         MODE_APP_CONNECT: app_up = 1'b1;
         MODE_APP_DISCONNECT: begin
            app_up = 1'b0;
            if (!hid_up) lights_off();
         end
         MODE_HID_CONNECT: hid_up = 1'b1;
         MODE_HID_DISCONNECT: begin
            hid_up = 1'b0;
            if (!app_up) lights_off();
         end
         MODE_PRESS: begin
            lights_on(cfg_shadow.preflash_warm, cfg_shadow.preflash_cool,
                      cfg_shadow.preflash_timeout_ms);
            if (app_up) begin
               trigger_id += 1;
               kind    = KIND_TRIGGER;
               id      = trigger_id;
               pressed = 1'b1;
            end
         end
         MODE_RELEASE: begin
            if (app_up) begin
               lights_on(cfg_shadow.regular_warm, cfg_shadow.regular_cool,
                         cfg_shadow.regular_timeout_ms);
               trigger_id += 1;
               kind        = KIND_TRIGGER;
               id          = trigger_id;
               awaited_ack = trigger_id;
            end else if (hid_up) begin
               // HID only: volume-up key, then key release
               lights_on(cfg_shadow.regular_warm, cfg_shadow.regular_cool,
                         cfg_shadow.regular_timeout_ms);
               due_results.push_back(result_now(KIND_NONE, '0, 1'b0, 1'b1, KEY_VOL_UP, 1'b0));
               due_results.push_back(result_now(KIND_NONE, '0, 1'b0, 1'b1, KEY_RELEASE, 1'b1));
               return;
            end else begin
               lights_off();
            end
         end
         MODE_COMMAND: begin
            case (ev.cmd_type)
               CMD_PING: begin
                  kind = KIND_ACK;
                  id   = ev.cmd_id;
               end
               CMD_FLASH: begin
                  lights_on(ev.flash_warm, ev.flash_cool, ev.flash_timeout_ms);
                  kind = KIND_ACK;
                  id   = ev.cmd_id;
               end
               CMD_OFF: begin
                  lights_off();
                  kind = KIND_ACK;
                  id   = ev.cmd_id;
               end
               CMD_ACK: begin
                  if (awaited_ack == ev.cmd_id) begin
                     lights_off();
                     awaited_ack = '0;
                  end
               end
               default: ;
            endcase
         end
         MODE_TICK: begin
            if (countdown_on) begin
               if (ticks_left <= 1) lights_off();
               else ticks_left -= 1;
            end
         end
      endcase
      due_results.push_back(result_now(kind, id, pressed, 1'b0, '0, 1'b1));
   endtask

   // ---------------------------------------------------------------- drivers

   // result-side stall bursts, started at random while idling is on
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // offer one item, hold it until taken, then update the model
   task automatic send_event(req_item_type ev);
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_controller(ev);
      events_sent++;
   endtask

   // stop sending and let every expected item come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_item_type ev_of(mode_type m, logic [2:0] code = CMD_PING,
         logic [7:0] id = '0, logic [7:0] w = '0, logic [7:0] c = '0,
         logic [15:0] dur = '0);
      req_item_type ev;
      ev.mode             = m;
      ev.cmd_type         = code;
      ev.cmd_id           = id;
      ev.flash_warm       = w;
      ev.flash_cool       = c;
      ev.flash_timeout_ms = dur;
      return ev;
   endfunction

   // noise event, weighted toward ticks, button and commands
   function automatic req_item_type random_event();
      req_item_type ev;
      int unsigned  pick = $urandom_range(0, 99);
      ev.cmd_id           = $urandom;
      ev.flash_warm       = $urandom;
      ev.flash_cool       = $urandom;
      ev.flash_timeout_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 24));
      if ($urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1) == 0) ev.flash_warm = '0;
         else ev.flash_cool = '0;
      end
      ev.cmd_type = cmd_code_type'($urandom_range(0, 3));
      if      (pick < 4)  ev.mode = MODE_APP_DISCONNECT;
      else if (pick < 7)  ev.mode = MODE_HID_DISCONNECT;
      else if (pick < 13) ev.mode = MODE_APP_CONNECT;
      else if (pick < 18) ev.mode = MODE_HID_CONNECT;
      else if (pick < 33) ev.mode = MODE_PRESS;
      else if (pick < 50) ev.mode = MODE_RELEASE;
      else if (pick < 72) ev.mode = MODE_COMMAND;
      else                ev.mode = MODE_TICK;
      if (ev.mode == MODE_COMMAND) begin
         if ($urandom_range(0, 9) == 0)
            ev.cmd_type = CMD_ACK + 3'($urandom_range(1, 4));
         else if (ev.cmd_type == CMD_ACK && $urandom_range(0, 4) < 3)
            ev.cmd_id = awaited_ack;
      end
      return ev;
   endfunction

   // ---------------------------------------------------------------- CSR port

   function automatic logic [CSR_DATA_W-1:0] reg_value(reg_index_type idx);
      case (idx)
         REG_REGULAR_WARM:        return 32'(cfg_shadow.regular_warm);
         REG_REGULAR_COOL:        return 32'(cfg_shadow.regular_cool);
         REG_REGULAR_TIMEOUT_MS:  return 32'(cfg_shadow.regular_timeout_ms);
         REG_PREFLASH_WARM:       return 32'(cfg_shadow.preflash_warm);
         REG_PREFLASH_COOL:       return 32'(cfg_shadow.preflash_cool);
         default:                 return 32'(cfg_shadow.preflash_timeout_ms);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_mask(reg_index_type idx);
      if (idx == REG_REGULAR_TIMEOUT_MS || idx == REG_PREFLASH_TIMEOUT_MS) return 32'hFFFF;
      return 32'hFF;
   endfunction

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_REGULAR_WARM:        cfg_shadow.regular_warm        = value[7:0];
         REG_REGULAR_COOL:        cfg_shadow.regular_cool        = value[7:0];
         REG_REGULAR_TIMEOUT_MS:  cfg_shadow.regular_timeout_ms  = value[15:0];
         REG_PREFLASH_WARM:       cfg_shadow.preflash_warm       = value[7:0];
         REG_PREFLASH_COOL:       cfg_shadow.preflash_cool       = value[7:0];
         REG_PREFLASH_TIMEOUT_MS: cfg_shadow.preflash_timeout_ms = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(reg_index_type idx);
      logic [CSR_DATA_W-1:0] want;
      want = reg_value(idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) begin
         $display("%0t: register %s expected %h, got %h", $time, idx.name(), want,
                  csr_prdata);
         mismatches++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(cfg_type s);
      csr_write(REG_REGULAR_WARM,        32'(s.regular_warm));
      csr_write(REG_REGULAR_COOL,        32'(s.regular_cool));
      csr_write(REG_REGULAR_TIMEOUT_MS,  32'(s.regular_timeout_ms));
      csr_write(REG_PREFLASH_WARM,       32'(s.preflash_warm));
      csr_write(REG_PREFLASH_COOL,       32'(s.preflash_cool));
      csr_write(REG_PREFLASH_TIMEOUT_MS, 32'(s.preflash_timeout_ms));
   endtask

   // ---------------------------------------------------------------- checker

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: result item with none expected, got %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("light_warm",      want.light_warm,      rsp_data.light_warm);
            check_field("light_cool",      want.light_cool,      rsp_data.light_cool);
            check_field("status_led",      want.status_led,      rsp_data.status_led);
            check_field("send_kind",       want.send_kind,       rsp_data.send_kind);
            check_field("send_id",         want.send_id,         rsp_data.send_id);
            check_field("trigger_pressed", want.trigger_pressed, rsp_data.trigger_pressed);
            check_field("hid_key_valid",   want.hid_key_valid,   rsp_data.hid_key_valid);
            check_field("hid_key",         want.hid_key,         rsp_data.hid_key);
            check_field("last",            want.last,            rsp_data.last);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // defaults after reset, all-ones and all-zeros per register, then defaults
   task automatic test_register_access();
      cfg_type defaults;
      defaults = cfg_shadow;
      for (int i = 0; i <= REG_PREFLASH_TIMEOUT_MS; i++) csr_check(reg_index_type'(i));
      for (int i = 0; i <= REG_PREFLASH_TIMEOUT_MS; i++) begin
         csr_write(reg_index_type'(i), reg_mask(reg_index_type'(i)));
         csr_check(reg_index_type'(i));
         csr_write(reg_index_type'(i), '0);
         csr_check(reg_index_type'(i));
      end
      apply_settings(defaults);
   endtask

   // link handling, button, every command and the countdown corners
   task automatic test_directed_events();
      send_event(ev_of(MODE_PRESS));                      // preflash with no link
      send_event(ev_of(MODE_RELEASE));                    // no link: lights off
      send_event(ev_of(MODE_HID_CONNECT));
      send_event(ev_of(MODE_RELEASE));                    // HID only: two keys
      send_event(ev_of(MODE_TICK));
      send_event(ev_of(MODE_APP_CONNECT));
      send_event(ev_of(MODE_APP_CONNECT));                // already linked
      send_event(ev_of(MODE_PRESS));
      send_event(ev_of(MODE_RELEASE));
      send_event(ev_of(MODE_COMMAND, CMD_ACK, 8'h05));    // wrong id
      send_event(ev_of(MODE_COMMAND, CMD_ACK, awaited_ack));
      send_event(ev_of(MODE_COMMAND, CMD_ACK, 8'h00));    // cleared id matches zero
      send_event(ev_of(MODE_COMMAND, CMD_PING, 8'hFF));
      send_event(ev_of(MODE_COMMAND, CMD_FLASH, 8'h80, 8'hFF, 8'hFF, 16'd0));
      send_event(ev_of(MODE_TICK));                       // zero duration ends at once
      send_event(ev_of(MODE_COMMAND, CMD_FLASH, 8'h01, 8'h00, 8'hFF, 16'd7));  // unlit
      send_event(ev_of(MODE_COMMAND, CMD_FLASH, 8'h7F, 8'hFF, 8'h01, 16'd2));
      send_event(ev_of(MODE_TICK));
      send_event(ev_of(MODE_TICK));                       // second tick ends it
      send_event(ev_of(MODE_COMMAND, CMD_FLASH, 8'h02, 8'h01, 8'h01, 16'hFFFF));
      send_event(ev_of(MODE_COMMAND, 3'(CMD_ACK + 4), 8'h55));  // unknown type
      send_event(ev_of(MODE_APP_DISCONNECT));             // HID still up, stays lit
      send_event(ev_of(MODE_HID_DISCONNECT));             // both down: lights off
      send_event(ev_of(MODE_COMMAND, CMD_OFF, 8'hAA));
      send_event(ev_of(MODE_TICK));                       // countdown idle
   endtask

   // button shots (press, hold, release, ack) mixed with noise events
   task automatic test_random_traffic(cfg_type setting, bit idle, int unsigned count);
      int unsigned target;
      wait_drained();
      apply_settings(setting);
      req_idle_on = idle;
      rsp_idle_on = idle;
      target      = events_sent + count;
      while (events_sent < target) begin
         if ($urandom_range(0, 1) == 0) begin
            send_event(ev_of(MODE_PRESS));
            repeat ($urandom_range(0, 3)) send_event(ev_of(MODE_TICK));
            send_event(ev_of(MODE_RELEASE));
            repeat ($urandom_range(0, 3)) send_event(ev_of(MODE_TICK));
            if ($urandom_range(0, 4) == 0)
               send_event(ev_of(MODE_COMMAND, CMD_ACK, 8'($urandom)));
            else
               send_event(ev_of(MODE_COMMAND, CMD_ACK, awaited_ack));
         end else begin
            send_event(random_event());
         end
      end
   endtask

   initial begin
      cfg_type s;
      cfg_shadow = '{regular_warm: REGULAR_WARM_RST, regular_cool: REGULAR_COOL_RST,
                     regular_timeout_ms: REGULAR_TIMEOUT_MS_RST,
                     preflash_warm: PREFLASH_WARM_RST, preflash_cool: PREFLASH_COOL_RST,
                     preflash_timeout_ms: PREFLASH_TIMEOUT_MS_RST};
      app_up      = 1'b0;
      hid_up      = 1'b0;
      trigger_id  = '0;
      awaited_ack = '0;
      lights_off();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_directed_events();

      // brightest flash, shortest countdown
      s = '{8'hFF, 8'hFF, 16'd1, 8'hFF, 8'hFF, 16'd1};
      test_random_traffic(s, 1'b1, PHASE_EVENTS);
      // dark channels and zero durations
      s = '{8'h00, 8'hFF, 16'd0, 8'hFF, 8'h00, 16'd0};
      test_random_traffic(s, 1'b1, PHASE_EVENTS);
      // random levels, short countdowns, no idling
      s = '{8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
            16'($urandom_range(2, 30)), 8'($urandom_range(1, 255)),
            8'($urandom_range(1, 255)), 16'($urandom_range(2, 30))};
      test_random_traffic(s, 1'b0, PHASE_EVENTS);
      // longest countdowns
      s = '{8'($urandom), 8'($urandom), 16'hFFFF, 8'($urandom), 8'($urandom), 16'hFFFF};
      test_random_traffic(s, 1'b1, PHASE_EVENTS);
      // closing phase at full rate
      s = '{8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
            16'($urandom_range(1, 12)), 8'($urandom_range(1, 255)),
            8'($urandom_range(1, 255)), 16'($urandom_range(1, 12))};
      test_random_traffic(s, 1'b0, PHASE_EVENTS);

      wait_drained();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #RUN_LIMIT;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
